// ----- hw/rtl/itp_pkg.sv -----
package itp_pkg;

  localparam int OPERATOR_DEPTH_DEFAULT = 16;
  localparam int ARGUMENT_DEPTH_DEFAULT = 8;

  // results kept per input token; beyond this only an error may replace the last one
  localparam int RES_COUNT_W = 5;
  localparam logic [RES_COUNT_W-1:0] RES_LIMIT = 5'd16;

  // operator stack entries: operator codes 0..3, open paren mark 4
  localparam logic [2:0] ENT_PLUS   = 3'd0;
  localparam logic [2:0] ENT_MINUS  = 3'd1;
  localparam logic [2:0] PAREN_MARK = 3'd4;

  typedef enum logic [2:0] {
    KIND_OPERAND  = 3'd0,
    KIND_CALL     = 3'd1,
    KIND_COMMA    = 3'd2,
    KIND_LPAREN   = 3'd3,
    KIND_RPAREN   = 3'd4,
    KIND_OPERATOR = 3'd5,
    KIND_END      = 3'd6
  } tok_kind_t;

  typedef enum logic [1:0] {
    OUT_OPERAND  = 2'd0,
    OUT_FUNC     = 2'd1,
    OUT_OPERATOR = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_PAREN = 2'd2,
    ERR_CALL  = 2'd3
  } err_code_t;

  typedef enum logic [2:0] {
    SRC_TOKEN,
    SRC_ARG,
    SRC_FUNC,
    SRC_OPER,
    SRC_ERR
  } res_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_OP_RD,
    ST_OP_EV,
    ST_OP_PUSH,
    ST_END_ERR,
    ST_ARG_RD,
    ST_ARG_EV,
    ST_CALL_END,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic      tok_load;
    logic      op_push_paren;
    logic      op_push_code;
    logic      op_pop;
    logic      op_clear;
    logic      arg_push;
    logic      arg_pop;
    logic      arg_clear;
    logic      call_open;
    logic      call_close;
    logic      open_left_set;
    logic      emit;
    logic      emit_last;
    logic      fin_flush;
    res_src_t  res_src;
    err_code_t res_err;
  } ctrl_cmd_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      in_call;
    logic      op_empty;
    logic      op_full;
    logic      op_last;
    logic      paren_none;
    logic      arg_empty;
    logic      arg_full;
    logic      arg_last;
    logic      top_is_paren;
    logic      top_lower;
    logic      open_left;
    logic      emit_ok;
    logic      out_free;
    logic      flush_ok;
  } dp_status_t;

  function automatic logic [1:0] op_rank(input logic [2:0] entry);
    logic [1:0] rank;
    case (entry)
      PAREN_MARK: rank = 2'd1;
      ENT_PLUS:   rank = 2'd2;
      ENT_MINUS:  rank = 2'd2;
      default:    rank = 2'd3;
    endcase
    return rank;
  endfunction

endpackage

// ----- hw/rtl/itp_dp.sv -----
module itp_dp import itp_pkg::*; #(
  parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEFAULT,
  parameter int ARGUMENT_DEPTH = ARGUMENT_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  token_kind,
  input  logic [1:0]  op_code,
  input  logic [15:0] token_index,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_op,
  output logic [15:0] out_index,
  output logic [1:0]  error_code,
  output logic        out_last
);

  localparam int OIW = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int AIW = (ARGUMENT_DEPTH > 1) ? $clog2(ARGUMENT_DEPTH) : 1;
  localparam int ACW = $clog2(ARGUMENT_DEPTH + 1);

  logic [2:0]  tok_kind;
  logic [1:0]  tok_code;
  logic [15:0] tok_index;

  logic [2:0]     operator_stack [OPERATOR_DEPTH];
  logic [2:0]     op_rd_data;
  logic [OCW-1:0] operator_count;
  logic [OCW-1:0] paren_count;
  logic [OCW-1:0] op_dec;
  logic [2:0]     op_wdata;

  logic [15:0]    argument_stack [ARGUMENT_DEPTH];
  logic [15:0]    arg_rd_data;
  logic [ACW-1:0] argument_count;
  logic [ACW-1:0] arg_dec;

  logic        inside_call;
  logic [15:0] call_function_index;
  logic        open_left;

  logic                   pend_valid;
  logic [1:0]             pend_kind;
  logic [1:0]             pend_op;
  logic [15:0]            pend_index;
  logic [1:0]             pend_err;
  logic [RES_COUNT_W-1:0] res_count;
  logic                   res_full;
  logic                   out_free;

  logic [1:0]  new_kind;
  logic [1:0]  new_op;
  logic [15:0] new_index;
  logic [1:0]  new_err;

  always_ff @(posedge clk) begin
    if (cmd.tok_load) begin
      tok_kind  <= token_kind;
      tok_code  <= op_code;
      tok_index <= token_index;
    end
  end

  assign op_dec   = operator_count - OCW'(1);
  assign arg_dec  = argument_count - ACW'(1);
  assign op_wdata = cmd.op_push_paren ? PAREN_MARK : {1'b0, tok_code};

  // stack memories: one write port, registered read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.op_push_paren || cmd.op_push_code) begin
      operator_stack[operator_count[OIW-1:0]] <= op_wdata;
    end
    op_rd_data <= operator_stack[op_dec[OIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.arg_push) begin
      argument_stack[argument_count[AIW-1:0]] <= tok_index;
    end
    arg_rd_data <= argument_stack[arg_dec[AIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operator_count      <= '0;
      paren_count         <= '0;
      argument_count      <= '0;
      inside_call         <= 1'b0;
      call_function_index <= '0;
      open_left           <= 1'b0;
    end else begin
      if (cmd.op_clear) begin
        operator_count <= '0;
        paren_count    <= '0;
      end else if (cmd.op_push_paren) begin
        operator_count <= operator_count + OCW'(1);
        paren_count    <= paren_count + OCW'(1);
      end else if (cmd.op_push_code) begin
        operator_count <= operator_count + OCW'(1);
      end else if (cmd.op_pop) begin
        operator_count <= op_dec;
        if (op_rd_data == PAREN_MARK) begin
          paren_count <= paren_count - OCW'(1);
        end
      end
      if (cmd.arg_clear) begin
        argument_count <= '0;
      end else if (cmd.arg_push) begin
        argument_count <= argument_count + ACW'(1);
      end else if (cmd.arg_pop) begin
        argument_count <= arg_dec;
      end
      if (cmd.call_open) begin
        inside_call         <= 1'b1;
        call_function_index <= tok_index;
      end else if (cmd.call_close) begin
        inside_call <= 1'b0;
      end
      if (cmd.tok_load) begin
        open_left <= 1'b0;
      end else if (cmd.open_left_set) begin
        open_left <= 1'b1;
      end
    end
  end

  always_comb begin
    new_kind  = OUT_OPERAND;
    new_op    = 2'd0;
    new_index = 16'd0;
    new_err   = ERR_NONE;
    case (cmd.res_src)
      SRC_TOKEN: new_index = tok_index;
      SRC_ARG:   new_index = arg_rd_data;
      SRC_FUNC: begin
        new_kind  = OUT_FUNC;
        new_index = call_function_index;
      end
      SRC_OPER: begin
        new_kind = OUT_OPERATOR;
        new_op   = op_rd_data[1:0];
      end
      SRC_ERR:   new_err = cmd.res_err;
      default:   new_err = ERR_NONE;
    endcase
  end

  assign out_free = !result_valid || !result_stall;
  assign res_full = (res_count == RES_LIMIT);

  // one result waits in the pending slot so that the last one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      res_count    <= '0;
    end else begin
      if (out_free) begin
        result_valid <= 1'b0;
      end
      if (cmd.tok_load) begin
        res_count <= '0;
      end
      if (cmd.emit_last) begin
        result_valid <= 1'b1;
        out_kind     <= new_kind;
        out_op       <= new_op;
        out_index    <= new_index;
        error_code   <= new_err;
        out_last     <= 1'b1;
      end else if (cmd.emit) begin
        if (!res_full) begin
          if (pend_valid) begin
            result_valid <= 1'b1;
            out_kind     <= pend_kind;
            out_op       <= pend_op;
            out_index    <= pend_index;
            error_code   <= pend_err;
            out_last     <= 1'b0;
          end
          pend_valid <= 1'b1;
          pend_kind  <= new_kind;
          pend_op    <= new_op;
          pend_index <= new_index;
          pend_err   <= new_err;
          res_count  <= res_count + RES_COUNT_W'(1);
        end else if (new_err != ERR_NONE) begin
          // an error takes the place of the last kept result
          pend_kind  <= new_kind;
          pend_op    <= new_op;
          pend_index <= new_index;
          pend_err   <= new_err;
        end
      end else if (cmd.fin_flush && pend_valid) begin
        result_valid <= 1'b1;
        out_kind     <= pend_kind;
        out_op       <= pend_op;
        out_index    <= pend_index;
        error_code   <= pend_err;
        out_last     <= 1'b1;
        pend_valid   <= 1'b0;
      end
    end
  end

  always_comb begin
    status.kind         = tok_kind_t'(tok_kind);
    status.in_call      = inside_call;
    status.op_empty     = (operator_count == '0);
    status.op_full      = (operator_count == OCW'(OPERATOR_DEPTH));
    status.op_last      = (operator_count == OCW'(1));
    status.paren_none   = (paren_count == '0);
    status.arg_empty    = (argument_count == '0);
    status.arg_full     = (argument_count == ACW'(ARGUMENT_DEPTH));
    status.arg_last     = (argument_count == ACW'(1));
    status.top_is_paren = (op_rd_data == PAREN_MARK);
    status.top_lower    = (op_rank(op_rd_data) < op_rank({1'b0, tok_code}));
    status.open_left    = open_left;
    status.emit_ok      = !pend_valid || out_free || res_full;
    status.out_free     = out_free;
    status.flush_ok     = !pend_valid || out_free;
  end

endmodule

// ----- hw/rtl/itp_ctrl.sv -----
module itp_ctrl import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       token_valid,
  output logic       token_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.res_src = SRC_TOKEN;
    cmd.res_err = ERR_NONE;
    state_next  = state;
    token_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (token_valid) begin
          cmd.tok_load = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        if (status.in_call) begin
          case (status.kind)
            KIND_OPERAND: begin
              if (!status.arg_full) begin
                cmd.arg_push = 1'b1;
                state_next   = ST_IDLE;
              end else if (status.out_free) begin
                cmd.emit_last = 1'b1;
                cmd.res_src   = SRC_ERR;
                cmd.res_err   = ERR_FULL;
                state_next    = ST_IDLE;
              end
            end
            KIND_COMMA: state_next = ST_IDLE;
            KIND_RPAREN: begin
              if (!status.arg_empty) begin
                state_next = ST_ARG_RD;
              end else if (status.out_free) begin
                cmd.emit_last  = 1'b1;
                cmd.res_src    = SRC_FUNC;
                cmd.call_close = 1'b1;
                state_next     = ST_IDLE;
              end
            end
            KIND_END: begin
              // the whole expression is abandoned
              if (status.out_free) begin
                cmd.call_close = 1'b1;
                cmd.arg_clear  = 1'b1;
                cmd.op_clear   = 1'b1;
                cmd.emit_last  = 1'b1;
                cmd.res_src    = SRC_ERR;
                cmd.res_err    = ERR_CALL;
                state_next     = ST_IDLE;
              end
            end
            default: begin
              if (status.out_free) begin
                cmd.emit_last = 1'b1;
                cmd.res_src   = SRC_ERR;
                cmd.res_err   = ERR_CALL;
                state_next    = ST_IDLE;
              end
            end
          endcase
        end else begin
          case (status.kind)
            KIND_OPERAND: begin
              if (status.out_free) begin
                cmd.emit_last = 1'b1;
                cmd.res_src   = SRC_TOKEN;
                state_next    = ST_IDLE;
              end
            end
            KIND_CALL: begin
              cmd.call_open = 1'b1;
              cmd.arg_clear = 1'b1;
              state_next    = ST_IDLE;
            end
            KIND_LPAREN: begin
              if (!status.op_full) begin
                cmd.op_push_paren = 1'b1;
                state_next        = ST_IDLE;
              end else if (status.out_free) begin
                cmd.emit_last = 1'b1;
                cmd.res_src   = SRC_ERR;
                cmd.res_err   = ERR_FULL;
                state_next    = ST_IDLE;
              end
            end
            KIND_RPAREN: begin
              if (!status.paren_none) begin
                state_next = ST_OP_RD;
              end else if (status.out_free) begin
                cmd.emit_last = 1'b1;
                cmd.res_src   = SRC_ERR;
                cmd.res_err   = ERR_PAREN;
                state_next    = ST_IDLE;
              end
            end
            KIND_OPERATOR: begin
              if (!status.op_empty) begin
                state_next = ST_OP_RD;
              end else begin
                cmd.op_push_code = 1'b1;
                state_next       = ST_IDLE;
              end
            end
            KIND_END: begin
              if (!status.op_empty) begin
                state_next = ST_OP_RD;
              end else begin
                state_next = ST_IDLE;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_OP_RD: state_next = ST_OP_EV;

      ST_OP_EV: begin
        case (status.kind)
          KIND_RPAREN: begin
            if (status.top_is_paren) begin
              cmd.op_pop = 1'b1;
              state_next = ST_FIN;
            end else if (status.emit_ok) begin
              cmd.emit    = 1'b1;
              cmd.res_src = SRC_OPER;
              cmd.op_pop  = 1'b1;
              state_next  = ST_OP_RD;
            end
          end
          KIND_OPERATOR: begin
            if (status.top_is_paren || status.top_lower) begin
              state_next = ST_OP_PUSH;
            end else if (status.emit_ok) begin
              cmd.emit    = 1'b1;
              cmd.res_src = SRC_OPER;
              cmd.op_pop  = 1'b1;
              state_next  = status.op_last ? ST_OP_PUSH : ST_OP_RD;
            end
          end
          KIND_END: begin
            if (status.top_is_paren) begin
              cmd.op_pop        = 1'b1;
              cmd.open_left_set = 1'b1;
              state_next        = status.op_last ? ST_END_ERR : ST_OP_RD;
            end else if (status.emit_ok) begin
              cmd.emit    = 1'b1;
              cmd.res_src = SRC_OPER;
              cmd.op_pop  = 1'b1;
              state_next  = status.op_last ? ST_END_ERR : ST_OP_RD;
            end
          end
          default: state_next = ST_FIN;
        endcase
      end

      ST_OP_PUSH: begin
        if (!status.op_full) begin
          cmd.op_push_code = 1'b1;
          state_next       = ST_FIN;
        end else if (status.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.res_src = SRC_ERR;
          cmd.res_err = ERR_FULL;
          state_next  = ST_FIN;
        end
      end

      ST_END_ERR: begin
        if (!status.open_left) begin
          state_next = ST_FIN;
        end else if (status.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.res_src = SRC_ERR;
          cmd.res_err = ERR_PAREN;
          state_next  = ST_FIN;
        end
      end

      ST_ARG_RD: state_next = ST_ARG_EV;

      ST_ARG_EV: begin
        // arguments leave in reverse order
        if (status.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.res_src = SRC_ARG;
          cmd.arg_pop = 1'b1;
          state_next  = status.arg_last ? ST_CALL_END : ST_ARG_RD;
        end
      end

      ST_CALL_END: begin
        if (status.emit_ok) begin
          cmd.emit       = 1'b1;
          cmd.res_src    = SRC_FUNC;
          cmd.call_close = 1'b1;
          state_next     = ST_FIN;
        end
      end

      ST_FIN: begin
        if (status.flush_ok) begin
          cmd.fin_flush = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// channel  | handshake                  | payload
// token    | token_valid, token_stall   | token_kind, op_code, token_index
// result   | result_valid, result_stall | out_kind, out_op, out_index, error_code, out_last
//
// a token settled at dispatch with no stack walk passes only ST_IDLE and ST_DISPATCH
// a stack walk adds a read and an evaluate state per entry examined (registered stack memory read),
// then may push or emit an error or the function; ST_FIN marks the last result
// rst is synchronous; it empties both stacks and closes any open call
// the next token is taken while the previous last result still sits in the
// output register; a stalled result output holds the controller only when a
// new result must move out
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEFAULT,
  parameter int ARGUMENT_DEPTH = ARGUMENT_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        token_valid,
  output logic        token_stall,
  input  logic [2:0]  token_kind,
  input  logic [1:0]  op_code,
  input  logic [15:0] token_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_op,
  output logic [15:0] out_index,
  output logic [1:0]  error_code,
  output logic        out_last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  itp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .status      (status),
    .cmd         (cmd)
  );

  itp_dp #(
    .OPERATOR_DEPTH (OPERATOR_DEPTH),
    .ARGUMENT_DEPTH (ARGUMENT_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .token_kind   (token_kind),
    .op_code      (op_code),
    .token_index  (token_index),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_kind     (out_kind),
    .out_op       (out_op),
    .out_index    (out_index),
    .error_code   (error_code),
    .out_last     (out_last)
  );

endmodule
